### rtl/hss_pkg.sv
`default_nettype none

package hss_pkg;

  localparam int HSS_NUM_SLOTS     = 9;
  localparam int HSS_LENGTH_FACTOR = 5;

  localparam int SLOT_W  = 4;
  localparam int BURST_W = 16;
  localparam int IDX_W   = 19;
  localparam int ACT_W   = 2;
  localparam int MAXIT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Action codes of an input word.
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP    = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HYBRID_ENABLE  = 2'd0;
  localparam logic [1:0] REG_WRAP_POINT     = 2'd1;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;

  localparam logic [SLOT_W-1:0]  WRAP_POINT_RST = 4'd1;
  localparam logic [MAXIT_W-1:0] MAX_ITER_RST   = 16'd250;

  typedef struct packed {
    logic               en;
    logic [BURST_W-1:0] burst;
    logic [IDX_W-1:0]   start_iter;
    logic [IDX_W-1:0]   stop_iter;
  } slot_entry_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/hss_ram.sv
`default_nettype none

module hss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/hybrid_slot_sequencer_core.sv
// Channel   | Handshake               | Ports
// ----------+-------------------------+-------------------------------------------------
// input     | start & !busy           | in_action, in_slot, in_slot_enable,
//           |                         | in_burst_count, in_start_iter, in_stop_iter
// result    | out_valid, one cycle    | out_slot_no, out_highest_slot, out_iter_index
// config    | psel & penable & pwrite | paddr, pwdata, prdata, pready (always high)
//
// Write and restart words give no result. A step outside the
// sequence gives its result in the cycle after it is accepted and leaves busy low.
// A step inside the sequence keeps busy high while it scans the slot table, which has a
// registered read and is read once per slot visited; skipped slots lengthen the scan.
// Synchronous active-low reset; slot table entries read as zero until written.
// Results cannot be stalled by the receiver.
`default_nettype none

module hybrid_slot_sequencer_core
  import hss_pkg::*;
#(
  parameter int NUM_SLOTS     = HSS_NUM_SLOTS,
  parameter int LENGTH_FACTOR = HSS_LENGTH_FACTOR
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [SLOT_W-1:0]  in_slot,
  input  wire logic               in_slot_enable,
  input  wire logic [BURST_W-1:0] in_burst_count,
  input  wire logic [IDX_W-1:0]   in_start_iter,
  input  wire logic [IDX_W-1:0]   in_stop_iter,
  output logic                    out_valid,
  output logic [SLOT_W-1:0]       out_slot_no,
  output logic [SLOT_W-1:0]       out_highest_slot,
  output logic [IDX_W-1:0]        out_iter_index,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int PTR_W = $clog2(NUM_SLOTS);
  localparam int TRY_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = IDX_W + 1;
  localparam int RF_W  = SLOT_W + 1;

  // Configuration registers.
  logic               hybrid_r;
  logic [SLOT_W-1:0]  repeat_r;
  logic [MAXIT_W-1:0] maxit_r;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hybrid_r <= 1'b0;
      repeat_r <= WRAP_POINT_RST;
      maxit_r  <= MAX_ITER_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HYBRID_ENABLE:  hybrid_r <= pwdata[0];
        REG_WRAP_POINT:     repeat_r <= pwdata[SLOT_W-1:0];
        REG_MAX_ITERATIONS: maxit_r  <= pwdata[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HYBRID_ENABLE:  prdata = DATA_W'(hybrid_r);
      REG_WRAP_POINT:     prdata = DATA_W'(repeat_r);
      REG_MAX_ITERATIONS: prdata = DATA_W'(maxit_r);
      default:            prdata = '0;
    endcase
  end

  // Sequencer state.
  seq_state_t         state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   scan_r, scan_nxt;
  logic [TRY_W-1:0]   tries_r, tries_nxt;
  logic [BURST_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PTR_W-1:0]   max_r, max_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic               ov_r, ov_nxt;
  logic [SLOT_W-1:0]  oslot_r, oslot_nxt;
  logic [SLOT_W-1:0]  ohigh_r, ohigh_nxt;
  logic [IDX_W-1:0]   oidx_r, oidx_nxt;

  // Slot table memory.
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  slot_entry_t        ram_wdata, ram_rdata, entry;

  hss_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Wrap target: the one-based wrap point clamped to 1..NUM_SLOTS, made zero-based.
  logic [RF_W-1:0]  rf_clamped;
  logic [PTR_W-1:0] wrap_slot;
  always_comb begin
    rf_clamped = RF_W'(repeat_r);
    if (rf_clamped == '0) begin
      rf_clamped = RF_W'(1);
    end
    if (rf_clamped > RF_W'(NUM_SLOTS)) begin
      rf_clamped = RF_W'(NUM_SLOTS);
    end
    wrap_slot = PTR_W'(rf_clamped - RF_W'(1));
  end

  logic [PTR_W-1:0] scan_next;
  assign scan_next = (scan_r == PTR_W'(NUM_SLOTS - 1)) ? wrap_slot : scan_r + 1'b1;

  logic [PTR_W-1:0] scan_next2;

  logic [CMP_W-1:0] seq_len;
  assign seq_len = CMP_W'(maxit_r) * CMP_W'(LENGTH_FACTOR);

  logic accept, in_range, active, usable, skip;
  assign accept   = start & ~busy;
  assign in_range = ({1'b0, in_slot} < RF_W'(NUM_SLOTS));
  assign active   = hybrid_r & (CMP_W'(idx_r) < seq_len);

  // An entry never written reads as the cleared value.
  assign entry  = valid_r[scan_r] ? ram_rdata : '0;
  assign usable = entry.en & (idx_r >= entry.start_iter) & (idx_r <= entry.stop_iter);
  assign skip   = ~usable & (tries_r < TRY_W'(NUM_SLOTS));

  assign ram_we          = accept & (in_action == ACT_WRITE) & in_range;
  assign ram_waddr       = in_slot[PTR_W-1:0];
  assign ram_wdata.en         = in_slot_enable;
  assign ram_wdata.burst      = in_burst_count;
  assign ram_wdata.start_iter = in_start_iter;
  assign ram_wdata.stop_iter  = in_stop_iter;
  assign ram_raddr       = (state_r == ST_IDLE) ? ptr_r : scan_next;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    scan_nxt  = scan_r;
    tries_nxt = tries_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    max_nxt   = max_r;
    valid_nxt = valid_r;
    ov_nxt    = 1'b0;
    oslot_nxt = oslot_r;
    ohigh_nxt = ohigh_r;
    oidx_nxt  = oidx_r;
    scan_next2 = scan_next;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_WRITE: begin
              if (in_range) begin
                valid_nxt[in_slot[PTR_W-1:0]] = 1'b1;
              end
            end
            ACT_RESTART: begin
              ptr_nxt = '0;
              cnt_nxt = '0;
              idx_nxt = '0;
              max_nxt = '0;
            end
            ACT_STEP: begin
              if (active) begin
                if (cnt_r != '1) begin
                  cnt_nxt = cnt_r + 1'b1;
                end
                scan_nxt  = ptr_r;
                tries_nxt = '0;
                state_nxt = ST_SCAN;
              end else begin
                ov_nxt    = 1'b1;
                oslot_nxt = '0;
                ohigh_nxt = SLOT_W'(max_r);
                oidx_nxt  = idx_r;
                if (idx_r != '1) begin
                  idx_nxt = idx_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (skip) begin
          // The read of the next slot is already under way this cycle.
          scan_nxt  = scan_next;
          tries_nxt = tries_r + 1'b1;
        end else begin
          if (entry.en && (scan_r > max_r)) begin
            max_nxt = scan_r;
          end
          if (cnt_r >= entry.burst) begin
            cnt_nxt = '0;
            ptr_nxt = scan_next2;
          end else begin
            ptr_nxt = scan_r;
          end
          ov_nxt    = 1'b1;
          oslot_nxt = SLOT_W'(scan_r);
          ohigh_nxt = SLOT_W'(max_nxt);
          oidx_nxt  = idx_r;
          if (idx_r != '1) begin
            idx_nxt = idx_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      scan_r  <= '0;
      tries_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      max_r   <= '0;
      valid_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      scan_r  <= scan_nxt;
      tries_r <= tries_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      max_r   <= max_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oslot_r <= oslot_nxt;
    ohigh_r <= ohigh_nxt;
    oidx_r  <= oidx_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_slot_no      = oslot_r;
  assign out_highest_slot = ohigh_r;
  assign out_iter_index   = oidx_r;

endmodule

`default_nettype wire
